### design/lbre_pkg.sv
// ----------------------------------------------------------------------------
// lbre_pkg
// Shared types and constants of the lossy block RLE encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lbre_pkg;

    // Longest run one result can carry
    localparam logic [7:0] RUN_MAX = 8'd255;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_THRESH = 2'd0,
        REG_BLOCK  = 2'd1,
        REG_ROW    = 2'd2
    } reg_idx_t;

    // Per-entry control carried from the front part to the back part
    typedef struct packed {
        logic two;   // entry holds two results
        logic end0;  // first result closes a block
        logic end1;  // second result closes a block
    } res_flags_t;

    localparam int FLAG_W = $bits(res_flags_t);

endpackage

`default_nettype wire

### design/lossy_block_rle_encoder_unit.sv
// ----------------------------------------------------------------------------
// lossy_block_rle_encoder_unit
// Lossy run-length encoder over blocks of image component samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock whenever the result queue has room and emits
// (run_value, run_count) results with tlast marking a block's closing run.
// A sample costs one compare and a counter update in the front stage; its
// results land in a four-entry queue feeding the master side, which sends
// one result per cycle while m_tready is high. A sample that both breaks a
// run and ends a block gives two results and holds the output for both;
// a long stretch of them stalls the input, otherwise one sample per cycle.
// Configuration writes go through APB; the user must keep the stream idle
// for them, the block does not enforce it; no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lossy_block_rle_encoder_unit #(
    parameter int SAMPLE_BITS = 8,
    parameter int COORD_BITS  = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // APB configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [3:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready,
    // sample stream; tdata: sample
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // run stream; tdata: run_value, run_count; tlast: block_end
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [((SAMPLE_BITS+8+7)/8)*8-1:0]         m_tdata,
    output logic                                       m_tlast
);

    localparam int MW      = ((SAMPLE_BITS + 8 + 7) / 8) * 8;
    localparam int ENTRY_W = 2 * (SAMPLE_BITS + 8) + lbre_pkg::FLAG_W;

    logic [7:0]            thresh_reg;
    logic [COORD_BITS-1:0] block_reg, row_reg;
    logic                  wr_en;
    lbre_pkg::reg_idx_t    idx;

    logic                  push, pop, full, head_valid;
    logic [ENTRY_W-1:0]    push_entry, head_entry;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = lbre_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= 8'd0;
            block_reg  <= COORD_BITS'(16);
            row_reg    <= COORD_BITS'(1);
        end else if (wr_en) begin
            case (idx)
                lbre_pkg::REG_THRESH: thresh_reg <= pwdata[7:0];
                lbre_pkg::REG_BLOCK:  block_reg  <= pwdata[COORD_BITS-1:0];
                lbre_pkg::REG_ROW:    row_reg    <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            lbre_pkg::REG_THRESH: prdata = 32'(thresh_reg);
            lbre_pkg::REG_BLOCK:  prdata = 32'(block_reg);
            lbre_pkg::REG_ROW:    prdata = 32'(row_reg);
            default:              prdata = 32'd0;
        endcase
    end

    lbre_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COORD_BITS  (COORD_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_thresh (thresh_reg),
        .cfg_block  (block_reg),
        .cfg_row    (row_reg),
        .in_valid   (s_tvalid),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (full)
    );

    lbre_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    lbre_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_W     (ENTRY_W),
        .MW          (MW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

### design/lbre_front.sv
// ----------------------------------------------------------------------------
// lbre_front
// Accepts samples, tracks run and block/row positions, builds result entries.
// ----------------------------------------------------------------------------
`default_nettype none

module lbre_front #(
    parameter int SAMPLE_BITS = 8,
    parameter int COORD_BITS  = 16,
    parameter int ENTRY_W     = 2 * (SAMPLE_BITS + 8) + lbre_pkg::FLAG_W
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [7:0]             cfg_thresh,
    input  wire logic [COORD_BITS-1:0]  cfg_block,
    input  wire logic [COORD_BITS-1:0]  cfg_row,
    input  wire logic                   in_valid,
    input  wire logic [SAMPLE_BITS-1:0] in_sample,
    output logic                        in_ready,
    output logic                        push,
    output logic [ENTRY_W-1:0]          push_entry,
    input  wire logic                   queue_full
);

    logic [SAMPLE_BITS-1:0] start_reg, start_next;
    logic [7:0]             len_reg, len_next;
    logic [COORD_BITS-1:0]  blk_pos_reg, blk_pos_next;
    logic [COORD_BITS-1:0]  row_pos_reg, row_pos_next;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   brk;
    logic                   open_new;
    logic [SAMPLE_BITS-1:0] start_a;
    logic [7:0]             len_a;
    logic [COORD_BITS:0]    next_blk, next_row, blk_lim, row_lim;
    logic                   row_end, blk_end, emit_end;
    lbre_pkg::res_flags_t   flags;
    logic [SAMPLE_BITS-1:0] val0, val1;
    logic [7:0]             cnt0, cnt1;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        diff = (in_sample >= start_reg) ? (in_sample - start_reg) : (start_reg - in_sample);
        brk      = (len_reg != 8'd0) && (diff > SAMPLE_BITS'(cfg_thresh));
        open_new = brk || (len_reg == 8'd0);
        start_a  = open_new ? in_sample : start_reg;
        len_a    = open_new ? 8'd1 : (len_reg + 8'd1);

        // a zero limit means the full coordinate range
        blk_lim  = {cfg_block == '0, cfg_block};
        row_lim  = {cfg_row == '0, cfg_row};
        next_blk = {1'b0, blk_pos_reg} + 1'b1;
        next_row = {1'b0, row_pos_reg} + 1'b1;
        row_end  = next_row >= row_lim;
        blk_end  = row_end || (next_blk >= blk_lim);
        emit_end = blk_end || (len_a == lbre_pkg::RUN_MAX);

        if (brk) begin
            val0       = start_reg;
            cnt0       = len_reg;
            flags.end0 = 1'b0;
            val1       = start_a;
            cnt1       = len_a;
            flags.end1 = blk_end;
            flags.two  = emit_end;
        end else begin
            val0       = start_a;
            cnt0       = len_a;
            flags.end0 = blk_end;
            val1       = start_a;
            cnt1       = len_a;
            flags.end1 = blk_end;
            flags.two  = 1'b0;
        end

        push       = accept && (brk || emit_end);
        push_entry = {flags, val1, cnt1, val0, cnt0};

        start_next   = start_reg;
        len_next     = len_reg;
        blk_pos_next = blk_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept) begin
            start_next   = start_a;
            len_next     = emit_end ? 8'd0 : len_a;
            blk_pos_next = blk_end ? '0 : next_blk[COORD_BITS-1:0];
            row_pos_next = row_end ? '0 : next_row[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= '0;
            len_reg     <= '0;
            blk_pos_reg <= '0;
            row_pos_reg <= '0;
        end else begin
            start_reg   <= start_next;
            len_reg     <= len_next;
            blk_pos_reg <= blk_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

endmodule

`default_nettype wire

### design/lbre_fifo.sv
// ----------------------------------------------------------------------------
// lbre_fifo
// Short queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lbre_fifo #(
    parameter int WIDTH = 35
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_entry
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    assign full       = count_reg == (PW+1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/lbre_back.sv
// ----------------------------------------------------------------------------
// lbre_back
// Drains queue entries onto the result stream, one or two results per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lbre_back #(
    parameter int SAMPLE_BITS = 8,
    parameter int ENTRY_W     = 2 * (SAMPLE_BITS + 8) + lbre_pkg::FLAG_W,
    parameter int MW          = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               head_valid,
    input  wire logic [ENTRY_W-1:0] head_entry,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [MW-1:0]           m_tdata,
    output logic                    m_tlast
);

    localparam int RW = SAMPLE_BITS + 8;

    logic                 phase_reg, phase_next;
    lbre_pkg::res_flags_t flags;
    logic [RW-1:0]        res0, res1;
    logic                 take;

    assign flags = lbre_pkg::res_flags_t'(head_entry[ENTRY_W-1 -: lbre_pkg::FLAG_W]);
    assign res1  = head_entry[2*RW-1 -: RW];
    assign res0  = head_entry[RW-1:0];

    always_comb begin
        m_tvalid = head_valid;
        // res layout is {value, count}; tdata wants count above value
        if (phase_reg) begin
            m_tdata = MW'({res1[7:0], res1[RW-1:8]});
            m_tlast = flags.end1;
        end else begin
            m_tdata = MW'({res0[7:0], res0[RW-1:8]});
            m_tlast = flags.end0;
        end
        take       = head_valid && m_tready;
        pop        = take && (phase_reg || !flags.two);
        phase_next = phase_reg;
        if (take) begin
            phase_next = phase_reg ? 1'b0 : flags.two;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

### design/lbre_checker.sv
// ----------------------------------------------------------------------------
// lbre_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lbre_checker #(
    parameter int SAMPLE_BITS = 8,
    parameter int MW          = 16
) (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          pready,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [MW-1:0] m_tdata,
    input wire logic          m_tlast
);

    // nothing comes out of reset pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // every run covers at least one sample
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[SAMPLE_BITS+7:SAMPLE_BITS] != 8'd0)
        else $error("run_count of zero");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind lossy_block_rle_encoder_unit lbre_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MW          (((SAMPLE_BITS + 8 + 7) / 8) * 8)
) u_lbre_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/sv/tb_lossy_block_rle_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lossy_block_rle_encoder_unit
// Self-checking bench for the lossy block RLE encoder.
// ----------------------------------------------------------------------------
// Streams 8-bit samples through the encoder under several register settings
// and predicts the (value, count, block end) runs it should emit. Both stream
// sides idle and stall at random. Registers change over APB only while the
// encoder is idle, so the run and block counters carry across settings.
// ----------------------------------------------------------------------------

module tb_lossy_block_rle_encoder_unit;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] count;
        logic       last;
    } run_t;

    // Predicts emitted runs and compares them with what the encoder sends
    class rle_scoreboard;
        logic [7:0]  thresh;
        logic [15:0] blk_sz;
        logic [15:0] row_w;
        logic [7:0]  run_val;
        logic [7:0]  run_len;
        logic [15:0] blk_pos;
        logic [15:0] row_pos;
        run_t        pending_runs[$];
        int          errors;

        function new();
            thresh  = 8'd0;
            blk_sz  = 16'd16;
            row_w   = 16'd1;
            run_val = 8'd0;
            run_len = 8'd0;
            blk_pos = 16'd0;
            row_pos = 16'd0;
            errors  = 0;
        endfunction

        function void set_reg(lbre_pkg::reg_idx_t idx, logic [15:0] val);
            case (idx)
                lbre_pkg::REG_THRESH: thresh = val[7:0];
                lbre_pkg::REG_BLOCK:  blk_sz = val;
                lbre_pkg::REG_ROW:    row_w  = val;
                default: ;
            endcase
        endfunction

        // zero acts as the full 16-bit range
        function logic [16:0] span(logic [15:0] v);
            return (v == 16'd0) ? 17'h10000 : {1'b0, v};
        endfunction

        function void close_run(logic last);
            run_t r;
            r.value = run_val;
            r.count = run_len;
            r.last  = last;
            pending_runs.insert(pending_runs.size(), r);
            run_len = 8'd0;
        endfunction

        function void note_sample(logic [7:0] s);
            logic [7:0]  delta;
            logic [16:0] nb;
            logic [16:0] nr;
            logic        row_done;
            logic        blk_done;
            if (run_len != 8'd0) begin
                delta = (s >= run_val) ? s - run_val : run_val - s;
                if (delta > thresh)
                    close_run(1'b0);
            end
            if (run_len == 8'd0) begin
                run_val = s;
                run_len = 8'd1;
            end else begin
                run_len = run_len + 8'd1;
            end
            nb = {1'b0, blk_pos} + 17'd1;
            nr = {1'b0, row_pos} + 17'd1;
            row_done = nr >= span(row_w);
            blk_done = row_done || nb >= span(blk_sz);
            row_pos = row_done ? 16'd0 : nr[15:0];
            blk_pos = blk_done ? 16'd0 : nb[15:0];
            if (blk_done || run_len >= lbre_pkg::RUN_MAX)
                close_run(blk_done);
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_run(logic [7:0] value, logic [7:0] count, logic last);
            run_t exp_run;
            if (pending_runs.size() == 0) begin
                report($sformatf("unexpected run value=%0d count=%0d last=%0b",
                                 value, count, last));
                return;
            end
            exp_run = pending_runs.pop_front();
            if (value !== exp_run.value)
                report($sformatf("run_value %0d, want %0d", value, exp_run.value));
            if (count !== exp_run.count)
                report($sformatf("run_count %0d, want %0d", count, exp_run.count));
            if (last !== exp_run.last)
                report($sformatf("block_end %0b, want %0b", last, exp_run.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;      // [7:0] sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [7:0] run_value, [15:8] run_count
    logic        m_tlast;             // block_end

    rle_scoreboard sb = new();
    logic          burst = 1'b0;      // no input gaps while set
    logic          steady = 1'b0;     // no output stalls while set
    int            stall_left = 0;
    int            cycles = 0;
    logic [7:0]    base = 8'd128;

    lossy_block_rle_encoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 20);
    endfunction

    // result side: check each transaction, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_run(m_tdata[7:0], m_tdata[15:8], m_tlast);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!steady)
                stall_left <= pick_gap();
        end
    end

    task automatic write_reg(input lbre_pkg::reg_idx_t idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_sample(input logic [7:0] v);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(v);
    endtask

    // drain all expected runs, then let samples with no result settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_runs.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [15:0] blk,
                              input logic [15:0] row);
        drain();
        write_reg(lbre_pkg::REG_THRESH, {8'd0, thr});
        write_reg(lbre_pkg::REG_BLOCK, blk);
        write_reg(lbre_pkg::REG_ROW, row);
    endtask

    // runs of nearby values, with a jump now and then and some pure noise
    function automatic logic [7:0] next_sample(int spread);
        int v;
        if ($urandom_range(0, 99) < 20)
            return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0)
            base = 8'($urandom_range(0, 255));
        v = int'(base) + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic random_phase(input int n);
        int          spread;
        logic [7:0]  thr;
        logic [15:0] blk;
        logic [15:0] row;
        case ($urandom_range(0, 3))
            0: thr = 8'd0;
            1: thr = 8'd255;
            2: thr = 8'($urandom_range(1, 20));
            default: thr = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
            0: blk = 16'd1;
            1: blk = 16'd65535;
            2: blk = 16'($urandom_range(2, 8));
            default: blk = 16'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 2))
            0: row = 16'd1;
            1: row = 16'd65535;
            default: row = 16'($urandom_range(1, 64));
        endcase
        set_config(thr, blk, row);
        burst  = ($urandom_range(0, 3) == 0);
        steady = ($urandom_range(0, 3) == 0);
        spread = (int'(thr) + 2 > 40) ? 40 : int'(thr) + 2;
        repeat (n) send_sample(next_sample(spread));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: one-sample rows, every sample closes its block
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'h55);
        send_sample(8'hAA);

        // joins at the threshold, breaks just past it, short last block
        set_config(8'd10, 16'd4, 16'd6);
        send_sample(8'd100);
        send_sample(8'd110);
        send_sample(8'd111);
        send_sample(8'd105);
        send_sample(8'd50);
        send_sample(8'd200);   // breaks the run and ends the row
        send_sample(8'd0);
        send_sample(8'd10);
        send_sample(8'd255);
        send_sample(8'd245);
        send_sample(8'd244);
        send_sample(8'd0);

        // shrink the block while one is open: closes on the next sample
        send_sample(8'd7);
        send_sample(8'd7);
        set_config(8'd255, 16'd1, 16'd65535);
        send_sample(8'd0);
        send_sample(8'd255);
        set_config(8'd0, 16'd65535, 16'd65535);
        send_sample(8'd3);
        send_sample(8'd3);
        send_sample(8'd4);

        repeat (6) random_phase(20);

        // long run under a wide threshold: the count caps at 255
        set_config(8'd255, 16'd65535, 16'd65535);
        burst = 1'b0;
        steady = 1'b0;
        repeat (260) send_sample(8'($urandom_range(0, 255)));
        set_config(8'd0, 16'd16, 16'd1);

        drain();
        repeat (20) @(posedge aclk);
        if (sb.pending_runs.size() != 0)
            sb.report($sformatf("%0d runs never arrived", sb.pending_runs.size()));
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### sim.f
design/lbre_pkg.sv
design/lbre_front.sv
design/lbre_fifo.sv
design/lbre_back.sv
design/lossy_block_rle_encoder_unit.sv
design/lbre_checker.sv
tb/sv/tb_lossy_block_rle_encoder_unit.sv
